// ----- hdl/oqpt_pkg.sv -----
// ----------------------------------------------------------------------------
// oqpt_pkg
// Shared widths, codes and types of the order queue position tracker.
// ----------------------------------------------------------------------------
package oqpt_pkg;

  localparam int unsigned PRICE_W    = 32;
  localparam int unsigned QTY_W      = 32;
  localparam int unsigned SEQ_W      = 64;
  localparam int unsigned TS_W       = 64;
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam int unsigned OQPT_QUEUE_DEPTH = 4;

  // event kinds
  localparam logic [REQ_W-1:0] REQ_JOIN   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_EXEC   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CANCEL = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OUR_PRICE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUR_SIDE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_JOIN_SEQ  = 2'd2;

  // classified operations handed from front to back
  localparam int unsigned OP_W = 3;
  localparam logic [OP_W-1:0] OP_NONE    = 3'd0;
  localparam logic [OP_W-1:0] OP_JOIN    = 3'd1;
  localparam logic [OP_W-1:0] OP_LEVEL   = 3'd2;
  localparam logic [OP_W-1:0] OP_THROUGH = 3'd3;
  localparam logic [OP_W-1:0] OP_CANCEL  = 3'd4;

  typedef struct packed {
    logic [PRICE_W-1:0] our_price;
    logic               our_side;
    logic [SEQ_W-1:0]   join_seq;
  } oqpt_cfg_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [QTY_W-1:0] qty;
    logic [QTY_W-1:0] level_qty;
    logic [TS_W-1:0]  ts;
    logic [TS_W-1:0]  match;
  } oqpt_op_t;

endpackage

// ----- hdl/oqpt_if.sv -----
// ----------------------------------------------------------------------------
// oqpt_if
// Valid/ready channel interfaces for market events and fill reports.
// ----------------------------------------------------------------------------
interface oqpt_in_if;
  import oqpt_pkg::*;

  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic               hist_known;
  logic               hist_side;
  logic [PRICE_W-1:0] hist_price;
  logic [SEQ_W-1:0]   hist_seq;
  logic [QTY_W-1:0]   qty;
  logic [QTY_W-1:0]   level_qty;
  logic [TS_W-1:0]    evt_ts;
  logic [TS_W-1:0]    match_id;

  modport source (
    output valid, req_type, hist_known, hist_side, hist_price, hist_seq,
           qty, level_qty, evt_ts, match_id,
    input  ready
  );

  modport sink (
    input  valid, req_type, hist_known, hist_side, hist_price, hist_seq,
           qty, level_qty, evt_ts, match_id,
    output ready
  );
endinterface

interface oqpt_out_if;
  import oqpt_pkg::*;

  logic               valid;
  logic               ready;
  logic               is_fill;
  logic [QTY_W-1:0]   fill_size;
  logic [PRICE_W-1:0] fill_px;
  logic [TS_W-1:0]    fill_ts;
  logic [TS_W-1:0]    fill_match;
  logic [QTY_W-1:0]   queue_ahead_now;
  logic [QTY_W-1:0]   remaining_now;

  modport source (
    output valid, is_fill, fill_size, fill_px, fill_ts, fill_match,
           queue_ahead_now, remaining_now,
    input  ready
  );

  modport sink (
    input  valid, is_fill, fill_size, fill_px, fill_ts, fill_match,
           queue_ahead_now, remaining_now,
    output ready
  );
endinterface

// ----- hdl/oqpt_front.sv -----
// ----------------------------------------------------------------------------
// oqpt_front
// Accepts market events and classifies them against our order.
// ----------------------------------------------------------------------------
module oqpt_front (
  input  logic                clk,
  input  logic                rst_n,
  input  oqpt_pkg::oqpt_cfg_t cfg,
  oqpt_in_if.sink             in_ch,
  output logic                push_valid,
  input  logic                push_ready,
  output oqpt_pkg::oqpt_op_t  push_data
);
  import oqpt_pkg::*;

  logic      v_r;
  logic      v_nxt;
  oqpt_op_t  op_r;
  oqpt_op_t  op_nxt;
  logic      in_fire;
  logic      same_side;
  logic      same_price;
  logic      through;

  assign in_ch.ready = !v_r || push_ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign same_side  = in_ch.hist_side == cfg.our_side;
  assign same_price = in_ch.hist_price == cfg.our_price;
  assign through    = cfg.our_side ? (in_ch.hist_price > cfg.our_price)
                                   : (in_ch.hist_price < cfg.our_price);

  always_comb begin
    op_nxt.qty       = in_ch.qty;
    op_nxt.level_qty = in_ch.level_qty;
    op_nxt.ts        = in_ch.evt_ts;
    op_nxt.match     = in_ch.match_id;
    op_nxt.op        = OP_NONE;
    unique case (in_ch.req_type)
      REQ_JOIN: begin
        op_nxt.op = OP_JOIN;
      end
      REQ_EXEC: begin
        if (in_ch.hist_known && same_side) begin
          if (same_price) begin
            op_nxt.op = OP_LEVEL;
          end else if (through) begin
            op_nxt.op = OP_THROUGH;
          end
        end
      end
      REQ_CANCEL: begin
        // equal sequence counts as ahead of us
        if (in_ch.hist_known && same_side && same_price &&
            in_ch.hist_seq <= cfg.join_seq) begin
          op_nxt.op = OP_CANCEL;
        end
      end
      default: begin
        op_nxt.op = OP_NONE;
      end
    endcase
  end

  always_comb begin
    v_nxt = v_r;
    if (in_fire) begin
      v_nxt = 1'b1;
    end else if (push_ready) begin
      v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else begin
      v_r <= v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r <= op_nxt;
    end
  end

  assign push_valid = v_r;
  assign push_data  = op_r;

endmodule

// ----- hdl/oqpt_fifo.sv -----
// ----------------------------------------------------------------------------
// oqpt_fifo
// Short queue of classified operations between front and back.
// ----------------------------------------------------------------------------
module oqpt_fifo #(
  parameter int unsigned DEPTH = oqpt_pkg::OQPT_QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_valid,
  output logic               push_ready,
  input  oqpt_pkg::oqpt_op_t push_data,
  output logic               pop_valid,
  input  logic               pop_ready,
  output oqpt_pkg::oqpt_op_t pop_data
);
  import oqpt_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  oqpt_op_t           mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   count_nxt;
  logic               push;
  logic               pop;

  assign push_ready = count_r != CNT_W'(DEPTH);
  assign pop_valid  = count_r != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_data   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hdl/oqpt_back.sv -----
// ----------------------------------------------------------------------------
// oqpt_back
// Applies classified operations to the queue position and remaining quantity.
// ----------------------------------------------------------------------------
module oqpt_back (
  input  logic                clk,
  input  logic                rst_n,
  input  oqpt_pkg::oqpt_cfg_t cfg,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  oqpt_pkg::oqpt_op_t  pop_data,
  oqpt_out_if.source          out_ch
);
  import oqpt_pkg::*;

  logic [QTY_W-1:0]   qp_r;
  logic [QTY_W-1:0]   qp_nxt;
  logic [QTY_W-1:0]   rem_r;
  logic [QTY_W-1:0]   rem_nxt;
  logic               out_v_r;
  logic               out_v_nxt;
  logic               fill_r;
  logic [QTY_W-1:0]   fq_r;
  logic [PRICE_W-1:0] price_r;
  logic [TS_W-1:0]    ts_r;
  logic [TS_W-1:0]    match_r;
  logic               fill;
  logic [QTY_W-1:0]   fq;
  logic               pop;
  logic [QTY_W-1:0]   lvl_used;
  logic [QTY_W-1:0]   lvl_left;
  logic [QTY_W-1:0]   lvl_qp;
  logic [QTY_W-1:0]   lvl_fq;
  logic [QTY_W-1:0]   thr_fq;

  assign pop_ready = !out_v_r || out_ch.ready;
  assign pop       = pop_valid && pop_ready;

  // same-level execution eats the queue ahead first
  assign lvl_used = (qp_r < pop_data.qty) ? qp_r : pop_data.qty;
  assign lvl_left = pop_data.qty - lvl_used;
  assign lvl_qp   = qp_r - lvl_used;
  assign lvl_fq   = (rem_r < lvl_left) ? rem_r : lvl_left;
  assign thr_fq   = (rem_r < pop_data.qty) ? rem_r : pop_data.qty;

  always_comb begin
    qp_nxt  = qp_r;
    rem_nxt = rem_r;
    fill    = 1'b0;
    fq      = '0;
    unique case (pop_data.op)
      OP_JOIN: begin
        qp_nxt  = pop_data.level_qty;
        rem_nxt = pop_data.qty;
      end
      OP_LEVEL: begin
        if (rem_r != '0) begin
          qp_nxt = lvl_qp;
          if (lvl_qp == '0 && lvl_left != '0) begin
            fill    = 1'b1;
            fq      = lvl_fq;
            rem_nxt = rem_r - lvl_fq;
          end
        end
      end
      OP_THROUGH: begin
        if (rem_r != '0) begin
          qp_nxt  = '0;
          fill    = 1'b1;
          fq      = thr_fq;
          rem_nxt = rem_r - thr_fq;
        end
      end
      OP_CANCEL: begin
        qp_nxt = lvl_qp;
      end
      default: begin
        qp_nxt = qp_r;
      end
    endcase
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (pop) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qp_r    <= '0;
      rem_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      if (pop) begin
        qp_r  <= qp_nxt;
        rem_r <= rem_nxt;
      end
    end
  end

  // hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (pop) begin
      fill_r  <= fill;
      fq_r    <= fq;
      price_r <= fill ? cfg.our_price : '0;
      ts_r    <= fill ? pop_data.ts : '0;
      match_r <= fill ? pop_data.match : '0;
    end
  end

  assign out_ch.valid           = out_v_r;
  assign out_ch.is_fill         = fill_r;
  assign out_ch.fill_size       = fq_r;
  assign out_ch.fill_px         = price_r;
  assign out_ch.fill_ts         = ts_r;
  assign out_ch.fill_match      = match_r;
  assign out_ch.queue_ahead_now = qp_r;
  assign out_ch.remaining_now   = rem_r;

endmodule

// ----- hdl/order_queue_position_tracker.sv -----
// ----------------------------------------------------------------------------
// order_queue_position_tracker
// Tracks one resting order's place in a FIFO price-level queue.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries market events (join, execute, cancel); out_ch returns one
//   report per event: fill flag, fill quantity, price, timestamp and match
//   number, plus the queue ahead and the remaining quantity afterwards.
//   cfg_we/cfg_idx/cfg_wdata write order price, order side and join sequence;
//   write them only while no transaction is in flight.
//   A report passes the classify register, the queue and the result register
//   before it is presented on out_ch.
//   Throughput: one transaction per cycle while out_ch does not stall.
//   Reset clears the configuration, queue position, remaining quantity and
//   the internal queue.
//   When out_ch stalls, the result register holds, the internal queue and
//   the classify register fill and then in_ch.ready drops; nothing is lost
//   or repeated.
// ----------------------------------------------------------------------------
module order_queue_position_tracker #(
  parameter int unsigned QUEUE_DEPTH = oqpt_pkg::OQPT_QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [oqpt_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  logic [oqpt_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  oqpt_in_if.sink                             in_ch,
  oqpt_out_if.source                          out_ch
);
  import oqpt_pkg::*;

  oqpt_cfg_t cfg_r;
  oqpt_cfg_t cfg_nxt;
  logic      push_valid;
  logic      push_ready;
  oqpt_op_t  push_data;
  logic      pop_valid;
  logic      pop_ready;
  oqpt_op_t  pop_data;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_OUR_PRICE: cfg_nxt.our_price = cfg_wdata[PRICE_W-1:0];
        CFG_OUR_SIDE:  cfg_nxt.our_side  = cfg_wdata[0];
        CFG_JOIN_SEQ:  cfg_nxt.join_seq  = cfg_wdata[SEQ_W-1:0];
        default:       cfg_nxt           = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  oqpt_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  oqpt_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  oqpt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

  a_fill_price : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.is_fill |-> out_ch.fill_px == cfg_r.our_price)
    else $error("fill price differs from order price");

  a_no_fill_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.is_fill |->
      out_ch.fill_size == '0 && out_ch.fill_px == '0 &&
      out_ch.fill_ts == '0 && out_ch.fill_match == '0)
    else $error("non-fill report carries fill data");

  a_fill_empty_queue : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.is_fill |-> out_ch.queue_ahead_now == '0)
    else $error("fill reported with quantity still ahead");

  a_stall_blocks_pop : assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !pop_ready)
    else $error("queue popped while result stalled");

endmodule
